// ----- hdl/psdg_pkg.sv -----
`timescale 1ns / 1ps

package psdg_pkg;

    localparam int PHASE_FRAC_BITS = 29;
    localparam int PHASE_W         = PHASE_FRAC_BITS + 3;

    localparam int PERIOD_W   = 11;
    localparam int DIVISOR_W  = PERIOD_W + 1;
    localparam int SCALE_W    = 40;
    localparam int DIV_STEPS  = SCALE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int SCOUNT_W   = 16;
    localparam int SCS_W      = 12;
    localparam int INTERVAL_W = 3 + SCS_W;

    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    localparam logic [2:0] REG_DUTY_MODE    = 3'd0;
    localparam logic [2:0] REG_SWEEP_PERIOD = 3'd1;
    localparam logic [2:0] REG_SWEEP_NEGATE = 3'd2;
    localparam logic [2:0] REG_SWEEP_SHIFT  = 3'd3;
    localparam logic [2:0] REG_HAS_SWEEP    = 3'd4;
    localparam logic [2:0] REG_PHASE_SCALE  = 3'd5;
    localparam logic [2:0] REG_SWEEP_CLOCK  = 3'd6;

    localparam logic [1:0] OP_TRIGGER = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_STOP    = 2'd2;

    localparam logic [7:0] DUTY_BITS [4] = '{8'h80, 8'h81, 8'hE1, 8'h7E};

    typedef struct packed {
        logic [1:0]          operation;
        logic [PERIOD_W-1:0] note_period;
    } t_in_item;

    typedef struct packed {
        logic                level_high;
        logic                sounding;
        logic [PERIOD_W-1:0] period_now;
    } t_out_item;

    typedef struct packed {
        logic [1:0]         duty_mode;
        logic [2:0]         sweep_period;
        logic               sweep_negate;
        logic [2:0]         sweep_shift;
        logic               has_sweep;
        logic [SCALE_W-1:0] phase_scale;
        logic [SCS_W-1:0]   sweep_clock_samples;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [SCALE_W-1:0]   dividend;
        logic [DIVISOR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [SCALE_W-1:0] quotient;
    } t_div_rsp;

    // shadow +/- (shadow >> shift); bit PERIOD_W flags overflow past 2047
    function automatic logic [PERIOD_W:0] psdg_next_sweep(
        input logic [PERIOD_W-1:0] shadow,
        input logic [2:0]          shift,
        input logic                negate
    );
        logic [PERIOD_W:0] ext;
        logic [PERIOD_W:0] delta;
        ext   = {1'b0, shadow};
        delta = ext >> shift;
        return negate ? (ext - delta) : (ext + delta);
    endfunction

endpackage

// ----- hdl/psdg_regs.sv -----
`timescale 1ns / 1ps

module psdg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [psdg_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [psdg_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [psdg_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    output psdg_pkg::t_cfg                     o_cfg
);
    import psdg_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[5:3];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duty_mode           <= 2'd2;
            r_cfg.sweep_period        <= 3'd0;
            r_cfg.sweep_negate        <= 1'b0;
            r_cfg.sweep_shift         <= 3'd0;
            r_cfg.has_sweep           <= 1'b1;
            r_cfg.phase_scale         <= SCALE_W'(64'd12765305066);
            r_cfg.sweep_clock_samples <= SCS_W'(345);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DUTY_MODE:    r_cfg.duty_mode           <= pwdata[1:0];
                REG_SWEEP_PERIOD: r_cfg.sweep_period        <= pwdata[2:0];
                REG_SWEEP_NEGATE: r_cfg.sweep_negate        <= pwdata[0];
                REG_SWEEP_SHIFT:  r_cfg.sweep_shift         <= pwdata[2:0];
                REG_HAS_SWEEP:    r_cfg.has_sweep           <= pwdata[0];
                REG_PHASE_SCALE:  r_cfg.phase_scale         <= pwdata[SCALE_W-1:0];
                REG_SWEEP_CLOCK:  r_cfg.sweep_clock_samples <= pwdata[SCS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_DUTY_MODE:    prdata = CFG_DATA_W'(r_cfg.duty_mode);
            REG_SWEEP_PERIOD: prdata = CFG_DATA_W'(r_cfg.sweep_period);
            REG_SWEEP_NEGATE: prdata = CFG_DATA_W'(r_cfg.sweep_negate);
            REG_SWEEP_SHIFT:  prdata = CFG_DATA_W'(r_cfg.sweep_shift);
            REG_HAS_SWEEP:    prdata = CFG_DATA_W'(r_cfg.has_sweep);
            REG_PHASE_SCALE:  prdata = CFG_DATA_W'(r_cfg.phase_scale);
            REG_SWEEP_CLOCK:  prdata = CFG_DATA_W'(r_cfg.sweep_clock_samples);
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- hdl/psdg_div.sv -----
`timescale 1ns / 1ps

module psdg_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psdg_pkg::t_div_req i_req,
    output psdg_pkg::t_div_rsp o_rsp
);
    import psdg_pkg::*;

    logic [SCALE_W-1:0]   r_q;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIVISOR_W-1:0] w_trial;
    logic                 w_ge;

    // one quotient bit per cycle, dividend shifts out as quotient shifts in
    assign w_trial = {r_rem[DIVISOR_W-2:0], r_q[SCALE_W-1]};
    assign w_ge    = (w_trial >= r_den);

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_q    <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[SCALE_W-2:0], w_ge};
                r_rem <= w_ge ? (w_trial - r_den) : w_trial;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- hdl/pulse_sweep_duty_generator_unit.sv -----
`timescale 1ns / 1ps

// Pulse channel with frequency sweep, one item per audio sample.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries an operation
// (trigger, sample tick, stop) and a note period. Every item gives exactly
// one result beat on o_out_valid / i_out_ready / o_out_data: duty bit,
// sounding flag and the period after the item.
// The block works on one item at a time. A trigger, and a tick that makes a
// sweep step, recomputes the phase step through a 40-step serial divider
// before its result is loaded; a stepping tick then also advances the phase.
// A stop, an idle operation or a tick while silent go straight to the result;
// a plain sounding tick advances the phase first. The next item is taken in the
// cycle after the result is loaded, so the serial divider sets the worst-case
// item rate.
// A finished result sits in an output register; the next item is accepted
// while it waits. If the receiver stalls, the following result holds in the
// block, and no further item is taken, until the output register frees up.
// Configuration is written through the APB-style port (64-bit data, register i at
// byte 8*i); the user must write only while the block is idle; it is not enforced.
// Synchronous active-low reset clears phase, periods, sweep state and the
// channel-on flag, and loads the register defaults.

module pulse_sweep_duty_generator_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  psdg_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output psdg_pkg::t_out_item             o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psdg_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [psdg_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [psdg_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import psdg_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_PHASE, S_FIN} t_state;

    t_cfg     w_cfg;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    t_state               r_state;
    logic [PHASE_W-1:0]   r_acc;
    logic [PHASE_W-1:0]   r_step;
    logic [PERIOD_W-1:0]  r_period;
    logic [PERIOD_W-1:0]  r_shadow;
    logic [SCOUNT_W-1:0]  r_scount;
    logic                 r_armed;
    logic                 r_on;
    logic                 r_is_tick;
    logic                 r_level;
    logic                 r_sounding;
    logic                 r_div_start;
    logic [DIVISOR_W-1:0] r_div_den;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 w_accept;
    logic                 w_out_free;
    logic [PERIOD_W:0]    w_nv;
    logic [PERIOD_W:0]    w_trig_nv;
    logic                 w_sw_active;
    logic [SCOUNT_W-1:0]  w_cnt_inc;
    logic [INTERVAL_W-1:0] w_interval;
    logic                 w_fire;
    logic [PHASE_W-1:0]   n_acc;
    logic [PHASE_W-1:0]   n_step;
    logic [7:0]           w_pattern;

    psdg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_div_req.start    = r_div_start;
    assign w_div_req.dividend = w_cfg.phase_scale;
    assign w_div_req.divisor  = r_div_den;

    psdg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid & o_in_ready;
    assign w_out_free  = ~r_out_valid | i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        w_nv        = psdg_next_sweep(r_shadow, w_cfg.sweep_shift, w_cfg.sweep_negate);
        w_trig_nv   = psdg_next_sweep(i_in_data.note_period, w_cfg.sweep_shift,
                                      w_cfg.sweep_negate);
        w_sw_active = w_cfg.has_sweep & r_armed & (w_cfg.sweep_period != 3'd0);
        w_cnt_inc   = (r_scount == '1) ? r_scount : (r_scount + 1'b1);
        w_interval  = INTERVAL_W'(w_cfg.sweep_period) *
                      INTERVAL_W'(w_cfg.sweep_clock_samples);
        w_fire      = w_sw_active & (w_cnt_inc >= SCOUNT_W'(w_interval));
        // saturate the quotient to the largest phase value below 8.0
        n_step      = (|w_div_rsp.quotient[SCALE_W-1:PHASE_W]) ? '1
                                                               : w_div_rsp.quotient[PHASE_W-1:0];
        n_acc       = r_acc + r_step;
        w_pattern   = DUTY_BITS[w_cfg.duty_mode];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_step      <= '0;
            r_period    <= '0;
            r_shadow    <= '0;
            r_scount    <= '0;
            r_armed     <= 1'b0;
            r_on        <= 1'b0;
            r_is_tick   <= 1'b0;
            r_level     <= 1'b0;
            r_sounding  <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_level    <= 1'b0;
                        r_sounding <= 1'b0;
                        r_is_tick  <= 1'b0;
                        r_state    <= S_FIN;
                        case (i_in_data.operation)
                            OP_TRIGGER: begin
                                r_period    <= i_in_data.note_period;
                                r_acc       <= '0;
                                r_on        <= 1'b1;
                                r_div_den   <= DIVISOR_W'(2048) -
                                               {1'b0, i_in_data.note_period};
                                r_div_start <= 1'b1;
                                r_state     <= S_DIV;
                                if (w_cfg.has_sweep) begin
                                    r_shadow <= i_in_data.note_period;
                                    r_scount <= '0;
                                    r_armed  <= (w_cfg.sweep_period != 3'd0) &&
                                                (w_cfg.sweep_shift != 3'd0) &&
                                                !w_trig_nv[PERIOD_W];
                                end
                            end
                            OP_TICK: begin
                                if (r_on) begin
                                    r_is_tick  <= 1'b1;
                                    r_sounding <= 1'b1;
                                    r_state    <= S_PHASE;
                                    if (w_sw_active) begin
                                        r_scount <= w_fire ? '0 : w_cnt_inc;
                                    end
                                    if (w_fire) begin
                                        if (w_nv[PERIOD_W]) begin
                                            // off from the next sample on
                                            r_on <= 1'b0;
                                        end else if (w_cfg.sweep_shift != 3'd0) begin
                                            r_shadow    <= w_nv[PERIOD_W-1:0];
                                            r_period    <= w_nv[PERIOD_W-1:0];
                                            r_div_den   <= DIVISOR_W'(2048) - w_nv;
                                            r_div_start <= 1'b1;
                                            r_state     <= S_DIV;
                                        end
                                    end
                                end
                            end
                            OP_STOP: r_on <= 1'b0;
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_step <= n_step;
                        if (r_is_tick) begin
                            // shadow already holds the new period: check the next step
                            if (w_nv[PERIOD_W]) begin
                                r_on <= 1'b0;
                            end
                            r_state <= S_PHASE;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_PHASE: begin
                    r_acc   <= n_acc;
                    r_level <= w_pattern[n_acc[PHASE_W-1 -: 3]];
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out.level_high <= r_level;
                        r_out.sounding   <= r_sounding;
                        r_out.period_now <= r_period;
                        r_out_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
